// ===== src/msq_pkg.sv =====
// Package for the modem power sequencer: word types, register reset values,
// request, outcome and pin codes, and the one-hot sequencer phase type.
// No dependencies.
`default_nettype none
package msq_pkg;

  localparam int NUM_REGS   = 8;
  localparam int IDX_BITS   = 3;
  localparam int CFG_WIDTH  = 16;

  localparam logic [IDX_BITS-1:0] REG_SETTLE       = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_POLL_IV      = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_POLL_ATT     = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_NORMAL_HOLD  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_FLASH_HOLD   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_DN_FIRST     = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_DN_RETRY     = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_BOOT_MODE    = 3'd7;

  localparam logic [7:0]  RST_SETTLE      = 8'd1;
  localparam logic [7:0]  RST_POLL_IV     = 8'd4;
  localparam logic [7:0]  RST_POLL_ATT    = 8'd10;
  localparam logic [15:0] RST_NORMAL_HOLD = 16'd300;
  localparam logic [15:0] RST_FLASH_HOLD  = 16'd50;
  localparam logic [15:0] RST_DN_FIRST    = 16'd50;
  localparam logic [15:0] RST_DN_RETRY    = 16'd70;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_POWER_UP = 2'd1;
  localparam logic [1:0] REQ_SHUTDOWN = 2'd2;

  localparam logic [2:0] OUT_NONE       = 3'd0;
  localparam logic [2:0] OUT_UP_OK      = 3'd1;
  localparam logic [2:0] OUT_UP_FAIL    = 3'd2;
  localparam logic [2:0] OUT_ALREADY_ON = 3'd3;
  localparam logic [2:0] OUT_DN_OK      = 3'd4;
  localparam logic [2:0] OUT_DN_FAIL    = 3'd5;
  localparam logic [2:0] OUT_ALREADY_OFF= 3'd6;
  localparam logic [2:0] OUT_REJECTED   = 3'd7;

  localparam logic [2:0] ST_SHUTDOWN_ACK  = 3'd6;
  localparam logic [2:0] ST_UNKNOWN       = 3'd7;
  localparam logic [1:0] AP_NONE          = 2'd0;
  localparam logic [1:0] AP_NO_BYPASS     = 2'd2;
  localparam logic [1:0] AP_SHUTDOWN_REQ  = 2'd3;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_UP_AP    = 9'b000000010,
    PH_UP_RST   = 9'b000000100,
    PH_UP_PWRON = 9'b000001000,
    PH_UP_POLL  = 9'b000010000,
    PH_UP_HOLD  = 9'b000100000,
    PH_DN_AP    = 9'b001000000,
    PH_DN_PWRON = 9'b010000000,
    PH_DN_WAIT  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  settle_ticks;
    logic [7:0]  poll_interval_ticks;
    logic [7:0]  poll_attempts;
    logic [15:0] normal_hold_ticks;
    logic [15:0] flash_hold_ticks;
    logic [15:0] shutdown_first_ticks;
    logic [15:0] shutdown_retry_ticks;
    logic        boot_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] modem_status_pins;
    logic       modem_resout;
  } req_word_t;

  typedef struct packed {
    logic [1:0] ap_status_pins;
    logic       pwron_pin;
    logic       reset_pin;
    logic       cmd_pins_driven;
    logic       cmd_pin_level;
    logic       busy_res;
    logic [2:0] outcome;
    logic [2:0] modem_status;
    logic       modem_power;
    logic       status_changed;
  } res_word_t;

endpackage
`default_nettype wire

// ===== src/msq_stream_if.sv =====
// Valid/ready channel carrying one word of a packed payload type.
// Payload types come from msq_pkg at the point of instantiation.
`default_nettype none
interface msq_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/msq_cfg_regs.sv =====
// Configuration register file for the modem power sequencer.
// Depends on msq_pkg for the register indexes, reset values and cfg_t.
`default_nettype none
module msq_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [msq_pkg::IDX_BITS-1:0]    cfg_index,
  input  wire logic [msq_pkg::CFG_WIDTH-1:0]   cfg_wdata,
  output msq_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks         <= msq_pkg::RST_SETTLE;
      cfg.poll_interval_ticks  <= msq_pkg::RST_POLL_IV;
      cfg.poll_attempts        <= msq_pkg::RST_POLL_ATT;
      cfg.normal_hold_ticks    <= msq_pkg::RST_NORMAL_HOLD;
      cfg.flash_hold_ticks     <= msq_pkg::RST_FLASH_HOLD;
      cfg.shutdown_first_ticks <= msq_pkg::RST_DN_FIRST;
      cfg.shutdown_retry_ticks <= msq_pkg::RST_DN_RETRY;
      cfg.boot_mode            <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        msq_pkg::REG_SETTLE:      cfg.settle_ticks         <= cfg_wdata[7:0];
        msq_pkg::REG_POLL_IV:     cfg.poll_interval_ticks  <= cfg_wdata[7:0];
        msq_pkg::REG_POLL_ATT:    cfg.poll_attempts        <= cfg_wdata[7:0];
        msq_pkg::REG_NORMAL_HOLD: cfg.normal_hold_ticks    <= cfg_wdata;
        msq_pkg::REG_FLASH_HOLD:  cfg.flash_hold_ticks     <= cfg_wdata;
        msq_pkg::REG_DN_FIRST:    cfg.shutdown_first_ticks <= cfg_wdata;
        msq_pkg::REG_DN_RETRY:    cfg.shutdown_retry_ticks <= cfg_wdata;
        msq_pkg::REG_BOOT_MODE:   cfg.boot_mode            <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/msq_seq.sv =====
// Sequencer state and next-state logic: one input word per step enable,
// producing the result word. Depends on msq_pkg.
`default_nettype none
module msq_seq #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire msq_pkg::cfg_t     cfg,
  input  wire msq_pkg::req_word_t word,
  output msq_pkg::res_word_t     res
);

  localparam int CW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  msq_pkg::phase_t           phase, phase_next;
  logic [COUNTER_BITS-1:0]   tick_count, tick_count_next;
  logic [7:0]                poll_count, poll_count_next;
  logic                      ack_seen, ack_seen_next;
  logic                      retry_done, retry_done_next;
  logic [2:0]                recorded_status;
  logic                      recorded_power;
  logic [1:0]                host_status, host_status_next;
  logic                      pwron, pwron_next;
  logic                      reset_out, reset_out_next;
  logic                      cmd_drive, cmd_drive_next;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic reached(input logic [COUNTER_BITS-1:0] t, input logic [15:0] v);
    logic [CW-1:0] te;
    logic [CW-1:0] ve;
    logic [CW-1:0] me;
    te = CW'(t);
    ve = CW'(v);
    me = CW'(CNT_MAX);
    reached = te >= ((ve > me) ? me : ve);
  endfunction

  logic [COUNTER_BITS-1:0] tc_inc;
  logic                    settle_hit;
  logic [7:0]              poll_iv, poll_att;
  logic                    poll_hit;
  logic [7:0]              poll_inc;
  logic [15:0]             hold;
  logic                    hold_zero;
  logic                    hold_hit;
  logic                    from_pwron;
  logic                    w_retry, w_ack;
  logic [COUNTER_BITS-1:0] w_tc;
  logic                    hit1, hit2;
  logic                    a_cur;
  logic [COUNTER_BITS-1:0] t_cur, wt_inc;
  logic [2:0]              outcome;
  logic                    changed;
  logic                    st_ack;

  always_comb begin
    tc_inc     = sat_inc(tick_count);
    settle_hit = reached(tc_inc, {8'd0, cfg.settle_ticks});
    poll_iv    = (cfg.poll_interval_ticks == 8'd0) ? 8'd1 : cfg.poll_interval_ticks;
    poll_att   = (cfg.poll_attempts == 8'd0) ? 8'd1 : cfg.poll_attempts;
    poll_hit   = reached(tc_inc, {8'd0, poll_iv});
    poll_inc   = (poll_count == 8'hff) ? poll_count : poll_count + 8'd1;
    hold       = cfg.boot_mode ? cfg.flash_hold_ticks : cfg.normal_hold_ticks;
    hold_zero  = hold == 16'd0;
    hold_hit   = reached(tc_inc, hold);
    st_ack     = word.modem_status_pins == msq_pkg::ST_SHUTDOWN_ACK;

    from_pwron = phase == msq_pkg::PH_DN_PWRON;
    w_retry    = from_pwron ? 1'b0 : retry_done;
    w_ack      = from_pwron ? 1'b0 : ack_seen;
    w_tc       = from_pwron ? '0 : tick_count;
    hit1       = reached(w_tc, w_retry ? cfg.shutdown_retry_ticks : cfg.shutdown_first_ticks);
    hit2       = cfg.shutdown_retry_ticks == 16'd0;
    a_cur      = hit1 ? 1'b0 : w_ack;
    t_cur      = hit1 ? '0 : w_tc;
    wt_inc     = sat_inc(t_cur);

    changed = (word.modem_status_pins != recorded_status) ||
              (word.modem_resout != recorded_power);

    phase_next       = phase;
    tick_count_next  = tick_count;
    poll_count_next  = poll_count;
    ack_seen_next    = ack_seen;
    retry_done_next  = retry_done;
    host_status_next = host_status;
    pwron_next       = pwron;
    reset_out_next   = reset_out;
    cmd_drive_next   = cmd_drive;
    outcome          = msq_pkg::OUT_NONE;

    if (word.req_type == msq_pkg::REQ_TICK) begin
      case (phase)
        msq_pkg::PH_UP_AP: begin
          tick_count_next = tc_inc;
          if (settle_hit) begin
            reset_out_next  = 1'b0;
            phase_next      = msq_pkg::PH_UP_RST;
            tick_count_next = '0;
          end
        end
        msq_pkg::PH_UP_RST: begin
          tick_count_next = tc_inc;
          if (settle_hit) begin
            pwron_next      = 1'b1;
            phase_next      = msq_pkg::PH_UP_PWRON;
            tick_count_next = '0;
          end
        end
        msq_pkg::PH_UP_PWRON: begin
          tick_count_next = tc_inc;
          if (settle_hit) begin
            pwron_next      = 1'b0;
            phase_next      = msq_pkg::PH_UP_POLL;
            poll_count_next = 8'd1;
            tick_count_next = '0;
            if (word.modem_resout) begin
              phase_next = msq_pkg::PH_UP_HOLD;
              if (hold_zero) begin
                cmd_drive_next = 1'b0;
                phase_next     = msq_pkg::PH_IDLE;
                outcome        = msq_pkg::OUT_UP_OK;
              end
            end
          end
        end
        msq_pkg::PH_UP_POLL: begin
          tick_count_next = tc_inc;
          if (poll_hit) begin
            if (poll_count >= poll_att) begin
              cmd_drive_next = 1'b0;
              phase_next     = msq_pkg::PH_IDLE;
              outcome        = msq_pkg::OUT_UP_FAIL;
            end else begin
              poll_count_next = poll_inc;
              tick_count_next = '0;
              if (word.modem_resout) begin
                phase_next = msq_pkg::PH_UP_HOLD;
                if (hold_zero) begin
                  cmd_drive_next = 1'b0;
                  phase_next     = msq_pkg::PH_IDLE;
                  outcome        = msq_pkg::OUT_UP_OK;
                end
              end
            end
          end
        end
        msq_pkg::PH_UP_HOLD: begin
          tick_count_next = tc_inc;
          if (hold_hit) begin
            cmd_drive_next = 1'b0;
            phase_next     = msq_pkg::PH_IDLE;
            outcome        = msq_pkg::OUT_UP_OK;
          end
        end
        msq_pkg::PH_DN_AP: begin
          tick_count_next = tc_inc;
          if (settle_hit) begin
            pwron_next      = 1'b1;
            phase_next      = msq_pkg::PH_DN_PWRON;
            tick_count_next = '0;
          end
        end
        msq_pkg::PH_DN_PWRON, msq_pkg::PH_DN_WAIT: begin
          if (from_pwron && !settle_hit) begin
            tick_count_next = tc_inc;
          end else begin
            phase_next      = msq_pkg::PH_DN_WAIT;
            retry_done_next = w_retry;
            ack_seen_next   = w_ack;
            tick_count_next = w_tc;
            if (hit1 && (w_retry || hit2)) begin
              pwron_next = 1'b0;
              phase_next = msq_pkg::PH_IDLE;
              outcome    = msq_pkg::OUT_DN_FAIL;
              if (!w_retry) begin
                reset_out_next  = 1'b1;
                retry_done_next = 1'b1;
                ack_seen_next   = 1'b0;
                tick_count_next = '0;
              end
            end else begin
              if (hit1) begin
                pwron_next      = 1'b0;
                reset_out_next  = 1'b1;
                retry_done_next = 1'b1;
              end
              ack_seen_next   = a_cur;
              tick_count_next = t_cur;
              if (!a_cur && st_ack) begin
                ack_seen_next = 1'b1;
                pwron_next    = 1'b0;
              end
              if (!word.modem_resout) begin
                pwron_next = 1'b0;
                phase_next = msq_pkg::PH_IDLE;
                outcome    = msq_pkg::OUT_DN_OK;
              end else begin
                tick_count_next = wt_inc;
              end
            end
          end
        end
        default: ;
      endcase
    end else if (word.req_type == msq_pkg::REQ_POWER_UP ||
                 word.req_type == msq_pkg::REQ_SHUTDOWN) begin
      if (phase != msq_pkg::PH_IDLE) begin
        outcome = msq_pkg::OUT_REJECTED;
      end else if (word.req_type == msq_pkg::REQ_POWER_UP) begin
        if (word.modem_resout) begin
          outcome = msq_pkg::OUT_ALREADY_ON;
        end else begin
          cmd_drive_next   = 1'b1;
          host_status_next = msq_pkg::AP_NO_BYPASS;
          phase_next       = msq_pkg::PH_UP_AP;
          tick_count_next  = '0;
        end
      end else begin
        if (!word.modem_resout) begin
          outcome = msq_pkg::OUT_ALREADY_OFF;
        end else begin
          host_status_next = msq_pkg::AP_SHUTDOWN_REQ;
          phase_next       = msq_pkg::PH_DN_AP;
          tick_count_next  = '0;
        end
      end
    end

    res.ap_status_pins  = host_status_next;
    res.pwron_pin       = pwron_next;
    res.reset_pin       = reset_out_next;
    res.cmd_pins_driven = cmd_drive_next;
    res.cmd_pin_level   = cmd_drive_next & cfg.boot_mode;
    res.busy_res        = phase_next != msq_pkg::PH_IDLE;
    res.outcome         = outcome;
    res.modem_status    = word.modem_status_pins;
    res.modem_power     = word.modem_resout;
    res.status_changed  = changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= msq_pkg::PH_IDLE;
      tick_count      <= '0;
      poll_count      <= 8'd0;
      ack_seen        <= 1'b0;
      retry_done      <= 1'b0;
      recorded_status <= msq_pkg::ST_UNKNOWN;
      recorded_power  <= 1'b0;
      host_status     <= msq_pkg::AP_NONE;
      pwron           <= 1'b0;
      reset_out       <= 1'b0;
      cmd_drive       <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      poll_count      <= poll_count_next;
      ack_seen        <= ack_seen_next;
      retry_done      <= retry_done_next;
      recorded_status <= word.modem_status_pins;
      recorded_power  <= word.modem_resout;
      host_status     <= host_status_next;
      pwron           <= pwron_next;
      reset_out       <= reset_out_next;
      cmd_drive       <= cmd_drive_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/modem_power_sequencer_core.sv =====
// Modem power sequencer top level: input word register, sequencer step,
// result word register. Depends on msq_pkg, msq_stream_if, msq_cfg_regs, msq_seq.
//
// Usage:
//   req carries one word per tick or command (req_type, status pins, reset-out);
//   rsp returns exactly one result word per request word, in order.
//   Both are valid/ready channels; a word moves when valid and ready are high.
//   cfg_we/cfg_index/cfg_wdata write one configuration register per cycle;
//   write only while no request word is in flight.
// Path: an accepted request word waits in the input word register; its step
//   result is then registered in the result word register.
// Throughput: one word per cycle while rsp is taken; a step is a single update.
// Reset (rst, synchronous): registers return to their defaults, the sequencer
//   goes idle with all pins released, and both word registers empty.
// Stall: when rsp is not taken the result register holds; the input register
//   takes one more word and then req.ready drops until rsp drains.
`default_nettype none
module modem_power_sequencer_core #(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  msq_stream_if.sink                           req,
  msq_stream_if.source                         rsp,
  input  wire logic                            cfg_we,
  input  wire logic [msq_pkg::IDX_BITS-1:0]    cfg_index,
  input  wire logic [msq_pkg::CFG_WIDTH-1:0]   cfg_wdata
);

  msq_pkg::cfg_t      cfg;
  msq_pkg::req_word_t in_word;
  logic               in_full;
  msq_pkg::res_word_t res_comb;
  msq_pkg::res_word_t res_word;
  logic               res_full;
  logic               advance;

  assign advance   = in_full && (!res_full || rsp.ready);
  assign req.ready = !in_full || advance;
  assign rsp.valid = res_full;
  assign rsp.data  = res_word;

  msq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  msq_seq #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cfg  (cfg),
    .word (in_word),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        res_full <= 1'b1;
      end else if (rsp.ready) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_word <= req.data;
    end
    if (advance) begin
      res_word <= res_comb;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for modem_power_sequencer_core: a cycle-free predictor of every field of the
// result word checks each one. Directed power-up and shutdown cases come first,
// then random command and tick sequences. Depends on msq_pkg and msq_stream_if.
`timescale 1ns / 1ps
module tb_top;

  localparam int CNT_BITS = 16;
  localparam int unsigned CNT_TOP = (1 << CNT_BITS) - 1;
  localparam int IDX_W = msq_pkg::IDX_BITS;
  localparam int CFG_W = msq_pkg::CFG_WIDTH;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  msq_stream_if #(.word_t(msq_pkg::req_word_t)) req_if ();
  msq_stream_if #(.word_t(msq_pkg::res_word_t)) rsp_if ();

  modem_power_sequencer_core #(.COUNTER_BITS(CNT_BITS)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  msq_pkg::phase_t seq_phase = msq_pkg::PH_IDLE;
  int unsigned tick_cnt = 0;
  int unsigned poll_cnt = 0;
  bit          ack_seen = 1'b0;
  bit          retry_done = 1'b0;
  logic [2:0]  rec_status = msq_pkg::ST_UNKNOWN;
  logic        rec_power = 1'b0;
  logic [1:0]  ap_level = msq_pkg::AP_NONE;
  logic        pwron_level = 1'b0;
  logic        reset_level = 1'b0;
  logic        cmd_drive = 1'b0;
  logic [15:0] cfg_val [msq_pkg::NUM_REGS];

  msq_pkg::res_word_t seq_outputs_q [$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  function automatic int unsigned clip_cnt(input int unsigned v);
    return (v > CNT_TOP) ? CNT_TOP : v;
  endfunction

  function automatic void bump_tick();
    if (tick_cnt < CNT_TOP) tick_cnt++;
  endfunction

  function automatic bit settle_done();
    bump_tick();
    return tick_cnt >= clip_cnt(cfg_val[msq_pkg::REG_SETTLE]);
  endfunction

  function automatic logic [2:0] hold_done();
    int unsigned hold;
    hold = cfg_val[msq_pkg::REG_BOOT_MODE][0] ? cfg_val[msq_pkg::REG_FLASH_HOLD]
                                              : cfg_val[msq_pkg::REG_NORMAL_HOLD];
    if (tick_cnt >= clip_cnt(hold)) begin
      cmd_drive = 1'b0;
      seq_phase = msq_pkg::PH_IDLE;
      return msq_pkg::OUT_UP_OK;
    end
    return msq_pkg::OUT_NONE;
  endfunction

  function automatic logic [2:0] poll_take(input logic ro);
    if (poll_cnt < 255) poll_cnt++;
    tick_cnt = 0;
    if (ro) begin
      seq_phase = msq_pkg::PH_UP_HOLD;
      return hold_done();
    end
    return msq_pkg::OUT_NONE;
  endfunction

  function automatic logic [2:0] shutdown_wait(input logic [2:0] st, input logic ro);
    int unsigned window;
    int attempt;
    for (attempt = 0; attempt < 2; attempt++) begin
      window = retry_done ? cfg_val[msq_pkg::REG_DN_RETRY] : cfg_val[msq_pkg::REG_DN_FIRST];
      if (tick_cnt >= clip_cnt(window)) begin
        pwron_level = 1'b0;
        if (retry_done) begin
          seq_phase = msq_pkg::PH_IDLE;
          return msq_pkg::OUT_DN_FAIL;
        end
        reset_level = 1'b1;
        retry_done = 1'b1;
        ack_seen = 1'b0;
        tick_cnt = 0;
      end else begin
        if (!ack_seen && st == msq_pkg::ST_SHUTDOWN_ACK) begin
          ack_seen = 1'b1;
          pwron_level = 1'b0;
        end
        if (!ro) begin
          pwron_level = 1'b0;
          seq_phase = msq_pkg::PH_IDLE;
          return msq_pkg::OUT_DN_OK;
        end
        bump_tick();
        return msq_pkg::OUT_NONE;
      end
    end
    return msq_pkg::OUT_NONE;
  endfunction

  function automatic msq_pkg::res_word_t sequence_step(input msq_pkg::req_word_t w);
    msq_pkg::res_word_t r;
    logic [2:0]  result;
    int unsigned iv;
    int unsigned att;
    r.status_changed = (w.modem_status_pins != rec_status) || (w.modem_resout != rec_power);
    rec_status = w.modem_status_pins;
    rec_power = w.modem_resout;
    result = msq_pkg::OUT_NONE;
    case (w.req_type)
      msq_pkg::REQ_TICK: begin
        case (seq_phase)
          msq_pkg::PH_UP_AP: if (settle_done()) begin
            reset_level = 1'b0;
            seq_phase = msq_pkg::PH_UP_RST;
            tick_cnt = 0;
          end
          msq_pkg::PH_UP_RST: if (settle_done()) begin
            pwron_level = 1'b1;
            seq_phase = msq_pkg::PH_UP_PWRON;
            tick_cnt = 0;
          end
          msq_pkg::PH_UP_PWRON: if (settle_done()) begin
            pwron_level = 1'b0;
            seq_phase = msq_pkg::PH_UP_POLL;
            poll_cnt = 0;
            result = poll_take(w.modem_resout);
          end
          msq_pkg::PH_UP_POLL: begin
            bump_tick();
            iv = (cfg_val[msq_pkg::REG_POLL_IV] != 0) ? cfg_val[msq_pkg::REG_POLL_IV] : 1;
            if (tick_cnt >= clip_cnt(iv)) begin
              att = (cfg_val[msq_pkg::REG_POLL_ATT] != 0) ? cfg_val[msq_pkg::REG_POLL_ATT] : 1;
              if (poll_cnt >= att) begin
                cmd_drive = 1'b0;
                seq_phase = msq_pkg::PH_IDLE;
                result = msq_pkg::OUT_UP_FAIL;
              end else begin
                result = poll_take(w.modem_resout);
              end
            end
          end
          msq_pkg::PH_UP_HOLD: begin
            bump_tick();
            result = hold_done();
          end
          msq_pkg::PH_DN_AP: if (settle_done()) begin
            pwron_level = 1'b1;
            seq_phase = msq_pkg::PH_DN_PWRON;
            tick_cnt = 0;
          end
          msq_pkg::PH_DN_PWRON: if (settle_done()) begin
            seq_phase = msq_pkg::PH_DN_WAIT;
            retry_done = 1'b0;
            ack_seen = 1'b0;
            tick_cnt = 0;
            result = shutdown_wait(w.modem_status_pins, w.modem_resout);
          end
          msq_pkg::PH_DN_WAIT: result = shutdown_wait(w.modem_status_pins, w.modem_resout);
          default: seq_phase = msq_pkg::PH_IDLE;
        endcase
      end
      msq_pkg::REQ_POWER_UP, msq_pkg::REQ_SHUTDOWN: begin
        if (seq_phase != msq_pkg::PH_IDLE) begin
          result = msq_pkg::OUT_REJECTED;
        end else if (w.req_type == msq_pkg::REQ_POWER_UP) begin
          if (w.modem_resout) begin
            result = msq_pkg::OUT_ALREADY_ON;
          end else begin
            cmd_drive = 1'b1;
            ap_level = msq_pkg::AP_NO_BYPASS;
            seq_phase = msq_pkg::PH_UP_AP;
            tick_cnt = 0;
          end
        end else if (!w.modem_resout) begin
          result = msq_pkg::OUT_ALREADY_OFF;
        end else begin
          ap_level = msq_pkg::AP_SHUTDOWN_REQ;
          seq_phase = msq_pkg::PH_DN_AP;
          tick_cnt = 0;
        end
      end
      default: ;
    endcase
    r.ap_status_pins = ap_level;
    r.pwron_pin = pwron_level;
    r.reset_pin = reset_level;
    r.cmd_pins_driven = cmd_drive;
    r.cmd_pin_level = cmd_drive ? cfg_val[msq_pkg::REG_BOOT_MODE][0] : 1'b0;
    r.busy_res = (seq_phase != msq_pkg::PH_IDLE);
    r.outcome = result;
    r.modem_status = rec_status;
    r.modem_power = rec_power;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] result %0d: %s", $time, result_count, what);
  endtask

  task automatic check_field(input string fname, input logic [2:0] got, input logic [2:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, predicted %0d", fname, got, want));
  endtask

  always @(posedge clk) begin
    msq_pkg::res_word_t want;
    if (!rst) begin
      if (req_if.valid && req_if.ready) seq_outputs_q.push_back(sequence_step(req_if.data));
      if (rsp_if.valid && rsp_if.ready) begin
        result_count++;
        if (seq_outputs_q.size() == 0) begin
          report_mismatch("result word with no request word outstanding");
        end else begin
          want = seq_outputs_q.pop_front();
          check_field("ap_status_pins", 3'(rsp_if.data.ap_status_pins),
                      3'(want.ap_status_pins));
          check_field("pwron_pin", 3'(rsp_if.data.pwron_pin), 3'(want.pwron_pin));
          check_field("reset_pin", 3'(rsp_if.data.reset_pin), 3'(want.reset_pin));
          check_field("cmd_pins_driven", 3'(rsp_if.data.cmd_pins_driven),
                      3'(want.cmd_pins_driven));
          check_field("cmd_pin_level", 3'(rsp_if.data.cmd_pin_level),
                      3'(want.cmd_pin_level));
          check_field("busy_res", 3'(rsp_if.data.busy_res), 3'(want.busy_res));
          check_field("outcome", rsp_if.data.outcome, want.outcome);
          check_field("modem_status", rsp_if.data.modem_status, want.modem_status);
          check_field("modem_power", 3'(rsp_if.data.modem_power), 3'(want.modem_power));
          check_field("status_changed", 3'(rsp_if.data.status_changed),
                      3'(want.status_changed));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 200);
      stall_mode = $urandom_range(0, 3);
    end
    mode_left--;
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
      2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
      default: rsp_if.ready <= ((mode_left % 5) < 3);
    endcase
  end

  task automatic send_word(input logic [1:0] rq, input logic [2:0] st, input logic ro);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    req_if.valid = 1'b1;
    req_if.data = '{req_type: rq, modem_status_pins: st, modem_resout: ro};
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (seq_outputs_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
    logic [CFG_W-1:0] masked;
    if (idx == msq_pkg::REG_BOOT_MODE) masked = CFG_W'(value & 32'h1);
    else if (idx <= msq_pkg::REG_POLL_ATT) masked = CFG_W'(value & 32'hFF);
    else masked = CFG_W'(value & 32'hFFFF);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = masked;
    cfg_val[idx] = masked;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_config(input int unsigned settle, input int unsigned iv,
                              input int unsigned att, input int unsigned nhold,
                              input int unsigned fhold, input int unsigned first_win,
                              input int unsigned retry_win, input int unsigned boot);
    wait_idle();
    write_reg(msq_pkg::REG_SETTLE, settle);
    write_reg(msq_pkg::REG_POLL_IV, iv);
    write_reg(msq_pkg::REG_POLL_ATT, att);
    write_reg(msq_pkg::REG_NORMAL_HOLD, nhold);
    write_reg(msq_pkg::REG_FLASH_HOLD, fhold);
    write_reg(msq_pkg::REG_DN_FIRST, first_win);
    write_reg(msq_pkg::REG_DN_RETRY, retry_win);
    write_reg(msq_pkg::REG_BOOT_MODE, boot);
  endtask

  task automatic run_sequences(input int items);
    int sent;
    int steps;
    int up_odds;
    int dn_odds;
    logic [1:0] cmd;
    sent = 0;
    while (sent < items) begin
      if (seq_phase == msq_pkg::PH_IDLE && $urandom_range(0, 9) < 7) begin
        cmd = $urandom_range(0, 1) ? msq_pkg::REQ_POWER_UP : msq_pkg::REQ_SHUTDOWN;
        up_odds = $urandom_range(0, 4);
        dn_odds = $urandom_range(1, 16);
        if (cmd == msq_pkg::REQ_POWER_UP) begin
          send_word(cmd, 3'($urandom_range(0, 7)), $urandom_range(0, 7) == 0);
        end else begin
          send_word(cmd, 3'($urandom_range(0, 7)), $urandom_range(0, 7) != 0);
        end
        sent++;
        steps = 0;
        while (seq_phase != msq_pkg::PH_IDLE && steps < 80 && sent < items) begin
          if ($urandom_range(0, 11) == 0) begin
            send_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
          end else if (cmd == msq_pkg::REQ_POWER_UP) begin
            send_word(msq_pkg::REQ_TICK, 3'($urandom_range(0, 7)),
                      $urandom_range(0, up_odds) == 0);
          end else begin
            send_word(msq_pkg::REQ_TICK,
                      ($urandom_range(0, 3) == 0) ? msq_pkg::ST_SHUTDOWN_ACK
                                                  : 3'($urandom_range(0, 7)),
                      $urandom_range(0, dn_odds) != 0);
          end
          steps++;
          sent++;
        end
      end else begin
        send_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  task automatic test_idle_requests();
    send_word(msq_pkg::REQ_TICK, 3'd0, 1'b1);
    send_word(msq_pkg::REQ_POWER_UP, 3'd5, 1'b1);
    send_word(msq_pkg::REQ_SHUTDOWN, 3'd5, 1'b0);
    send_word(REQ_UNUSED, msq_pkg::ST_UNKNOWN, 1'b1);
  endtask

  task automatic test_zero_timing_power_up();
    apply_config(0, 0, 0, 0, 2, 1, 1, 0);
    send_word(msq_pkg::REQ_POWER_UP, 3'd0, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd0, 1'b0);
    send_word(msq_pkg::REQ_SHUTDOWN, 3'd3, 1'b1);
    send_word(msq_pkg::REQ_TICK, 3'd0, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd0, 1'b1);
    send_word(msq_pkg::REQ_POWER_UP, 3'd7, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd7, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd7, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd7, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd7, 1'b0);
  endtask

  task automatic test_boot_mode_switch();
    apply_config(0, 0, 0, 3, 2, 1, 1, 0);
    send_word(msq_pkg::REQ_POWER_UP, 3'd1, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd1, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd1, 1'b0);
    send_word(msq_pkg::REQ_TICK, 3'd1, 1'b1);
    wait_idle();
    write_reg(msq_pkg::REG_BOOT_MODE, 1);
    send_word(msq_pkg::REQ_TICK, 3'd2, 1'b1);
    send_word(msq_pkg::REQ_TICK, 3'd2, 1'b1);
  endtask

  task automatic test_shutdown_windows();
    apply_config(0, 0, 0, 0, 0, 0, 0, 1);
    send_word(msq_pkg::REQ_SHUTDOWN, 3'd4, 1'b1);
    send_word(msq_pkg::REQ_TICK, 3'd4, 1'b1);
    send_word(msq_pkg::REQ_TICK, 3'd4, 1'b1);
    apply_config(0, 0, 0, 0, 0, 4, 4, 1);
    send_word(msq_pkg::REQ_SHUTDOWN, 3'd4, 1'b1);
    send_word(msq_pkg::REQ_TICK, 3'd4, 1'b1);
    send_word(msq_pkg::REQ_TICK, msq_pkg::ST_SHUTDOWN_ACK, 1'b1);
    send_word(msq_pkg::REQ_TICK, msq_pkg::ST_SHUTDOWN_ACK, 1'b0);
  endtask

  task automatic test_random_defaults();
    apply_config(msq_pkg::RST_SETTLE, msq_pkg::RST_POLL_IV, msq_pkg::RST_POLL_ATT,
                 msq_pkg::RST_NORMAL_HOLD, msq_pkg::RST_FLASH_HOLD,
                 msq_pkg::RST_DN_FIRST, msq_pkg::RST_DN_RETRY, 0);
    run_sequences(230);
  endtask

  task automatic test_random_small();
    int round;
    for (round = 0; round < 7; round++) begin
      apply_config($urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 5),
                   $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 12),
                   $urandom_range(0, 12), $urandom_range(0, 1));
      run_sequences(230);
    end
  endtask

  task automatic test_max_settings();
    apply_config(255, 255, 255, 65535, 65535, 65535, 65535, 1);
    run_sequences(110);
  endtask

  initial begin
    cfg_val[msq_pkg::REG_SETTLE] = msq_pkg::RST_SETTLE;
    cfg_val[msq_pkg::REG_POLL_IV] = msq_pkg::RST_POLL_IV;
    cfg_val[msq_pkg::REG_POLL_ATT] = msq_pkg::RST_POLL_ATT;
    cfg_val[msq_pkg::REG_NORMAL_HOLD] = msq_pkg::RST_NORMAL_HOLD;
    cfg_val[msq_pkg::REG_FLASH_HOLD] = msq_pkg::RST_FLASH_HOLD;
    cfg_val[msq_pkg::REG_DN_FIRST] = msq_pkg::RST_DN_FIRST;
    cfg_val[msq_pkg::REG_DN_RETRY] = msq_pkg::RST_DN_RETRY;
    cfg_val[msq_pkg::REG_BOOT_MODE] = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_idle_requests();
    test_zero_timing_power_up();
    test_boot_mode_switch();
    test_shutdown_windows();
    test_random_defaults();
    test_random_small();
    test_max_settings();
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
